// ----- hdl/dual_release_rms_compressor_defines.svh -----
// Assertion macros for the dual-release RMS compressor checker.
// Included by the checker file; no other dependencies.
`ifndef DUAL_RELEASE_RMS_COMPRESSOR_DEFINES_SVH
`define DUAL_RELEASE_RMS_COMPRESSOR_DEFINES_SVH

// Same-cycle implication, off during reset
`define DRC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define DRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset
`define DRC_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/drc_pkg.sv -----
// Shared types, constants and tables of the dual-release RMS compressor.
// No dependencies; used by the log unit, the top, the checker and the testbench.
package drc_pkg;

   // Widths fixed by the word formats
   localparam int SAMPLE_BITS  = 24;
   localparam int CHAN_W       = 3;
   localparam int CHAN_SLOTS   = 2 ** CHAN_W;
   localparam int CHANNELS_DEF = 8;
   localparam int ENV_W        = 32;
   localparam int COEF_W       = 24;
   localparam int RED_W        = 15;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_FAST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_SLOW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_ATT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_REL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS       = 3'd7;

   // Fixed-point constants
   localparam logic [24:0] Q24_ONE       = 25'h100_0000;
   localparam logic [23:0] Q24_HALF      = 24'h80_0000;
   localparam logic [23:0] Q24_MAX       = 24'hFF_FFFF;
   localparam logic [14:0] DB_FLOOR      = 15'd30720;
   localparam logic [17:0] DB_PER_OCTAVE = 18'd197283;
   localparam logic [21:0] OCTAVE_PER_DB = 22'd2786635;

   typedef struct packed {
      logic [CHAN_W-1:0]             channel;
      logic signed [SAMPLE_BITS-1:0] sample_in;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0]             channel_out;
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic [RED_W-1:0]              reduction_db;
   } rsp_word_type;

   // One memory word of per-channel state
   typedef struct packed {
      logic [ENV_W-1:0]  fast;
      logic [ENV_W-1:0]  slow;
      logic [COEF_W-1:0] weight;
   } chan_state_type;

   // Status from the log unit
   typedef struct packed {
      logic             done;
      logic [RED_W-1:0] level;
   } log_stat_type;

   typedef logic [31:0] root_tbl_type [16];

   // Factors 2^(-2^-(k+1)) in Q30: each the integer square root of the previous, from 0.5
   function automatic root_tbl_type root_table();
      root_tbl_type tbl;
      logic [63:0]  r;
      logic [63:0]  x;
      logic [63:0]  q;
      logic [63:0]  b;
      r = 64'd1 << 29;
      for (int k = 0; k < 16; k++) begin
         x = r << 30;
         q = 64'd0;
         b = 64'd1 << 62;
         for (int i = 0; i < 32; i++) begin
            if (x >= q + b) begin
               x = x - (q + b);
               q = (q >> 1) + b;
            end else begin
               q = q >> 1;
            end
            b = b >> 2;
         end
         r = q;
         tbl[k] = r[31:0];
      end
      return tbl;
   endfunction

   localparam root_tbl_type ROOT_TBL = root_table();

endpackage

// ----- hdl/drc_log_unit.sv -----
// Envelope to dB converter: normalize, 16 squaring steps, scale to Q7.8.
// Depends on drc_pkg.
module drc_log_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [drc_pkg::ENV_W-1:0]  env,
   output drc_pkg::log_stat_type      stat
);
   import drc_pkg::*;

   localparam logic [2:0] L_IDLE = 3'd0;
   localparam logic [2:0] L_NORM = 3'd1;
   localparam logic [2:0] L_SQ   = 3'd2;
   localparam logic [2:0] L_MUL  = 3'd3;
   localparam logic [2:0] L_RND  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [3:0]       cnt_ff;
   logic [31:0]      m_ff;
   logic [4:0]       sh_ff;
   logic [15:0]      frac_ff;
   logic [39:0]      prod_ff;
   logic             done_ff;
   logic [RED_W-1:0] level_ff;
   logic [63:0]      sq;
   logic [32:0]      sq_rnd;
   logic [21:0]      lvl_oct;
   logic [40:0]      lvl_sum;

   // Square the mantissa, Q1.31
   assign sq      = 64'(m_ff) * 64'(m_ff);
   assign sq_rnd  = 33'((65'(sq) + 65'(64'd1 << 30)) >> 31);
   assign lvl_oct = (22'(6'(sh_ff) + 6'd1) << 16) - 22'(frac_ff);
   assign lvl_sum = 41'(prod_ff) + 41'(Q24_HALF);

   // Sequence the steps
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         L_IDLE: if (start && env != '0) state_in = L_NORM;
         L_NORM: if (cnt_ff == 4'd4) state_in = L_SQ;
         L_SQ:   if (cnt_ff == 4'd15) state_in = L_MUL;
         L_MUL:  state_in = L_RND;
         L_RND:  state_in = L_IDLE;
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == L_RND) || (state_ff == L_IDLE && start && env == '0);
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         L_IDLE: begin
            m_ff     <= env;
            sh_ff    <= '0;
            cnt_ff   <= '0;
            frac_ff  <= '0;
            level_ff <= DB_FLOOR;
         end
         L_NORM: begin
            // binary search for the top set bit
            case (cnt_ff)
               4'd0: if (m_ff[31:16] == '0) begin
                  m_ff <= m_ff << 16; sh_ff <= sh_ff + 5'd16;
               end
               4'd1: if (m_ff[31:24] == '0) begin
                  m_ff <= m_ff << 8; sh_ff <= sh_ff + 5'd8;
               end
               4'd2: if (m_ff[31:28] == '0) begin
                  m_ff <= m_ff << 4; sh_ff <= sh_ff + 5'd4;
               end
               4'd3: if (m_ff[31:30] == '0) begin
                  m_ff <= m_ff << 2; sh_ff <= sh_ff + 5'd2;
               end
               default: if (!m_ff[31]) begin
                  m_ff <= m_ff << 1; sh_ff <= sh_ff + 5'd1;
               end
            endcase
            cnt_ff <= (cnt_ff == 4'd4) ? 4'd0 : cnt_ff + 4'd1;
         end
         L_SQ: begin
            // one fraction bit per squaring
            frac_ff <= {frac_ff[14:0], sq_rnd[32]};
            m_ff    <= sq_rnd[32] ? sq_rnd[32:1] : sq_rnd[31:0];
            cnt_ff  <= cnt_ff + 4'd1;
         end
         L_MUL: prod_ff <= 40'(lvl_oct) * 40'(DB_PER_OCTAVE);
         L_RND: level_ff <= lvl_sum[24+RED_W-1:24];
         default: ;
      endcase
   end

   assign stat.done  = done_ff;
   assign stat.level = level_ff;

endmodule

// ----- hdl/dual_release_rms_compressor.sv -----
// Dual-release RMS compressor: one tagged sample in, one processed sample out.
// Depends on drc_pkg and drc_log_unit.
//
// Usage:
//  - req channel carries {channel, sample_in}; rsp channel returns
//    {channel_out, sample_out, reduction_db}. Both use valid/stall.
//  - Per-channel envelopes and blend weight live in one memory with a
//    registered read; one item is in work at a time.
//  - A word for a channel beyond CHANNELS goes straight to the result; in
//    bypass the channel state is updated first; compressing adds the log
//    unit and the gain loop (no log steps for a zero blended envelope).
//    The next word is taken the cycle after the result is loaded.
//  - Compressing runs the 16-step mantissa squaring in the log unit and
//    the 16-step gain product loop, each one multiply per cycle.
//  - Reset: control and configuration registers to their reset values
//    (bypass on); every channel's state reads as zero until first written.
//  - A stalled result holds in the output register; a new word is still
//    accepted and worked on, and waits for the register before finishing.
//  - Write csr_* only while idle.
module dual_release_rms_compressor #(
   parameter int CHANNELS = drc_pkg::CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  drc_pkg::req_word_type             req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output drc_pkg::rsp_word_type             rsp_word,
   input  logic                              csr_we,
   input  logic [drc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [drc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import drc_pkg::*;

   localparam int SB      = SAMPLE_BITS;
   localparam int DEPTH   = (CHANNELS < CHAN_SLOTS) ? CHANNELS : CHAN_SLOTS;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RECT_SH = 2 * (SB - 1) - ENV_W;
   localparam int RSH     = (RECT_SH > 0) ? RECT_SH : 0;
   localparam int LSH     = (RECT_SH < 0) ? -RECT_SH : 0;
   localparam int SQ_W    = 2 * SB + 2;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_READ  = 5'd1;
   localparam logic [4:0] S_PREV  = 5'd2;
   localparam logic [4:0] S_POLE  = 5'd3;
   localparam logic [4:0] S_WB    = 5'd4;
   localparam logic [4:0] S_BLEND = 5'd5;
   localparam logic [4:0] S_ENV   = 5'd6;
   localparam logic [4:0] S_LOG   = 5'd7;
   localparam logic [4:0] S_RED   = 5'd8;
   localparam logic [4:0] S_REDS  = 5'd9;
   localparam logic [4:0] S_EXPM  = 5'd10;
   localparam logic [4:0] S_EXP   = 5'd11;
   localparam logic [4:0] S_GAIN  = 5'd12;
   localparam logic [4:0] S_APPLY = 5'd13;
   localparam logic [4:0] S_SCALE = 5'd14;
   localparam logic [4:0] S_ROUND = 5'd15;
   localparam logic [4:0] S_DONE  = 5'd16;

   logic [4:0]              state_ff, state_in;

   // configuration
   logic [COEF_W-1:0]       attack_ff, relf_ff, rels_ff, watt_ff, wrel_ff;
   logic signed [15:0]      thr_ff;
   logic [15:0]             ratio_ff;
   logic                    bypass_ff;

   // item registers
   logic [CHAN_W-1:0]       chan_ff;
   logic [SB-1:0]           mag_ff;
   logic                    neg_ff;
   logic [ENV_W-1:0]        rect_ff;
   logic [IDX_W-1:0]        idx_ff;

   // state memory
   chan_state_type          mem [DEPTH];
   chan_state_type          rd_ff;
   logic                    rd_vld_ff;
   logic [DEPTH-1:0]        valid_ff;
   chan_state_type          cur;
   chan_state_type          nst;
   chan_state_type          nst_ff;
   chan_state_type          bl_src;
   logic                    mem_we;

   // datapath registers
   logic [56:0]             pa_ff;
   logic [55:0]             pb_ff;
   logic                    att_ff;
   logic [47:0]             wx_ff;
   logic [48:0]             wt_ff;
   logic [55:0]             fx_ff, sx_ff;
   logic [56:0]             ft_ff, st_ff;
   logic [15:0]             over_ff;
   logic [31:0]             rprod_ff;
   logic [RED_W-1:0]        red_ff;
   logic [36:0]             eprod_ff;
   logic [20:0]             e_ff;
   logic [3:0]              cnt_ff;
   logic [30:0]             v_ff;
   logic [24:0]             gain_ff;
   logic [SB+24:0]          pm_ff;
   logic [SB-1:0]           res_samp_ff;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff;

   // combinational
   logic                    accept;
   logic                    in_range;
   logic [SB-1:0]           s_u;
   logic [SB-1:0]           mag_in;
   logic [2*SB-1:0]         sq;
   logic [SQ_W-1:0]         rect_wide;
   logic [ENV_W-1:0]        rect_in;
   logic [57:0]             bl_sum;
   logic [COEF_W-1:0]       cw, cf, cs, tw;
   logic [49:0]             w_sum;
   logic [57:0]             f_sum, s_sum;
   logic                    log_start;
   log_stat_type            log_stat;
   logic signed [17:0]      over_s;
   logic [32:0]             red_sum;
   logic [37:0]             e_sum;
   logic [61:0]             vr;
   logic [61:0]             vr_sum;
   logic [31:0]             g_sum;
   logic [SB+25:0]          pm_sum;
   logic [SB-1:0]           ym;
   logic                    rsp_load;

   // Accept and rectify the incoming word
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign in_range  = (int'(req_word.channel) < CHANNELS);
   assign s_u       = req_word.sample_in;
   assign mag_in    = s_u[SB-1] ? (~s_u + SB'(1)) : s_u;
   assign sq        = (2*SB)'(mag_in) * (2*SB)'(mag_in);
   assign rect_wide = (SQ_W'(sq) << LSH) >> RSH;
   assign rect_in   = (|rect_wide[SQ_W-1:ENV_W]) ? '1 : rect_wide[ENV_W-1:0];

   // Blend: shared by the previous and the updated state
   assign cur    = rd_vld_ff ? rd_ff : '0;
   assign bl_src = (state_ff == S_READ) ? cur : nst_ff;
   assign bl_sum = 58'(pa_ff) + 58'(pb_ff) + 58'(Q24_HALF);

   // Coefficient choice by attack flag
   assign cw = att_ff ? watt_ff : wrel_ff;
   assign tw = att_ff ? '0 : Q24_MAX;
   assign cf = att_ff ? attack_ff : relf_ff;
   assign cs = att_ff ? attack_ff : rels_ff;

   // One-pole updates
   assign w_sum      = 50'(wx_ff) + 50'(wt_ff) + 50'(Q24_HALF);
   assign f_sum      = 58'(fx_ff) + 58'(ft_ff) + 58'(Q24_HALF);
   assign s_sum      = 58'(sx_ff) + 58'(st_ff) + 58'(Q24_HALF);
   assign nst.weight = w_sum[47:24];
   assign nst.fast   = f_sum[55:24];
   assign nst.slow   = s_sum[55:24];
   assign mem_we     = (state_ff == S_WB);

   // Level to reduction to gain
   assign log_start = (state_ff == S_ENV);
   assign over_s    = 18'sd0 - $signed({3'b000, log_stat.level}) - 18'(thr_ff);
   assign red_sum   = 33'(rprod_ff) + 33'(17'h8000);
   assign e_sum     = 38'(eprod_ff) + 38'(17'h8000);
   assign vr        = 62'(v_ff) * 62'(ROOT_TBL[cnt_ff][30:0]);
   assign vr_sum    = vr + 62'(31'h2000_0000);
   assign g_sum     = 32'(v_ff) + 32'd32;
   assign pm_sum    = (SB+26)'(pm_ff) + (SB+26)'(Q24_HALF);
   assign ym        = pm_sum[SB+23:24];

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   drc_log_unit u_log (
      .clock (clock),
      .reset (reset),
      .start (log_start),
      .env   (bl_sum[55:24]),
      .stat  (log_stat)
   );

   // Sequence one word at a time
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = in_range ? S_READ : S_DONE;
         S_READ:  state_in = S_PREV;
         S_PREV:  state_in = S_POLE;
         S_POLE:  state_in = S_WB;
         S_WB:    state_in = bypass_ff ? S_DONE : S_BLEND;
         S_BLEND: state_in = S_ENV;
         S_ENV:   state_in = S_LOG;
         S_LOG:   if (log_stat.done) state_in = S_RED;
         S_RED:   state_in = S_REDS;
         S_REDS:  state_in = S_EXPM;
         S_EXPM:  state_in = S_EXP;
         S_EXP:   state_in = S_GAIN;
         S_GAIN:  if (cnt_ff == 4'd15) state_in = S_APPLY;
         S_APPLY: state_in = S_SCALE;
         S_SCALE: state_in = S_ROUND;
         S_ROUND: state_in = S_DONE;
         S_DONE:  if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         attack_ff    <= '0;
         relf_ff      <= '0;
         rels_ff      <= '0;
         watt_ff      <= '0;
         wrel_ff      <= '0;
         thr_ff       <= '0;
         ratio_ff     <= '0;
         bypass_ff    <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mem_we) valid_ff[idx_ff] <= 1'b1;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ATTACK:       attack_ff <= csr_wdata;
               CSR_RELEASE_FAST: relf_ff   <= csr_wdata;
               CSR_RELEASE_SLOW: rels_ff   <= csr_wdata;
               CSR_WEIGHT_ATT:   watt_ff   <= csr_wdata;
               CSR_WEIGHT_REL:   wrel_ff   <= csr_wdata;
               CSR_THRESHOLD:    thr_ff    <= csr_wdata[15:0];
               CSR_RATIO:        ratio_ff  <= csr_wdata[15:0];
               CSR_BYPASS:       bypass_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // State memory: read at accept, write back after the pole update
   always_ff @(posedge clock) begin
      if (mem_we) mem[idx_ff] <= nst;
      if (accept && in_range) begin
         rd_ff     <= mem[req_word.channel[IDX_W-1:0]];
         rd_vld_ff <= valid_ff[req_word.channel[IDX_W-1:0]];
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            chan_ff     <= req_word.channel;
            mag_ff      <= mag_in;
            neg_ff      <= s_u[SB-1];
            rect_ff     <= rect_in;
            idx_ff      <= req_word.channel[IDX_W-1:0];
            res_samp_ff <= s_u;
            red_ff      <= '0;
         end
         S_READ, S_BLEND: begin
            pa_ff <= 57'(bl_src.fast) * 57'(Q24_ONE - 25'(bl_src.weight));
            pb_ff <= 56'(bl_src.slow) * 56'(bl_src.weight);
         end
         S_PREV: att_ff <= (34'(rect_ff) > bl_sum[57:24]);
         S_POLE: begin
            wx_ff <= 48'(cw) * 48'(cur.weight);
            wt_ff <= 49'(Q24_ONE - 25'(cw)) * 49'(tw);
            fx_ff <= 56'(cf) * 56'(cur.fast);
            ft_ff <= 57'(Q24_ONE - 25'(cf)) * 57'(rect_ff);
            sx_ff <= 56'(cs) * 56'(cur.slow);
            st_ff <= 57'(Q24_ONE - 25'(cs)) * 57'(rect_ff);
         end
         S_WB: nst_ff <= nst;
         S_LOG: over_ff <= over_s[17] ? '0 : over_s[15:0];
         S_RED: rprod_ff <= 32'(over_ff) * 32'(ratio_ff);
         S_REDS: begin
            // saturate the reduction at the floor
            red_ff <= (red_sum[32:16] > 17'(DB_FLOOR)) ? DB_FLOOR : red_sum[30:16];
         end
         S_EXPM: eprod_ff <= 37'(red_ff) * 37'(OCTAVE_PER_DB);
         S_EXP: begin
            e_ff   <= e_sum[36:16];
            v_ff   <= 31'h4000_0000;
            cnt_ff <= '0;
         end
         S_GAIN: begin
            if (e_ff[4'd15 - cnt_ff]) v_ff <= vr_sum[60:30];
            cnt_ff <= cnt_ff + 4'd1;
         end
         S_APPLY: gain_ff <= (e_ff[20:16] == 5'd31) ? '0 : (g_sum[30:6] >> e_ff[20:16]);
         S_SCALE: pm_ff <= (SB+25)'(mag_ff) * (SB+25)'(gain_ff);
         S_ROUND: res_samp_ff <= neg_ff ? (~ym + SB'(1)) : ym;
         S_DONE: begin
            if (rsp_load) begin
               rsp_word_ff.channel_out  <= chan_ff;
               rsp_word_ff.sample_out   <= res_samp_ff;
               rsp_word_ff.reduction_db <= red_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- hdl/drc_checker.sv -----
// Port-level checker for the dual-release RMS compressor, bound to the top.
// Depends on drc_pkg and dual_release_rms_compressor_defines.svh.
`include "dual_release_rms_compressor_defines.svh"

module drc_checker #(
   parameter int CHANNELS = drc_pkg::CHANNELS_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input drc_pkg::rsp_word_type             rsp_word
);
   import drc_pkg::*;

   // Hold a stalled result word
   `DRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "stalled result word changed")

   // Block takes one word at a time
   `DRC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "second word accepted while busy")

   // Reduction never passes the floor
   `DRC_ASSERT_SAME(a_red_range, clock, reset, rsp_valid, rsp_word.reduction_db <= DB_FLOOR, "reduction above floor")

   // Unmapped channels pass with no reduction
   `DRC_ASSERT_SAME(a_oob_chan, clock, reset, rsp_valid && (int'(rsp_word.channel_out) >= CHANNELS), rsp_word.reduction_db == '0, "reduction on unmapped channel")

   // Reset drops the result valid
   `DRC_ASSERT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid, "result valid after reset")

endmodule

bind dual_release_rms_compressor drc_checker #(.CHANNELS(CHANNELS)) u_drc_checker (.*);

// ----- tb/tb_dual_release_rms_compressor.sv -----
// Self-checking testbench for the dual-release RMS compressor.
// Depends on drc_pkg and dual_release_rms_compressor; predicts every result in a class.
`timescale 1ns / 100ps

import drc_pkg::*;

class compressor_scoreboard;
   // register copy
   logic [23:0] att_c, relf_c, rels_c, watt_c, wrel_c;
   logic signed [15:0] thresh;
   logic [15:0] ratio;
   logic bypass_on;
   // per-channel state
   logic [31:0] fast_env [8];
   logic [31:0] slow_env [8];
   logic [23:0] blend_w [8];
   rsp_word_type pending_words [$];
   int errors;
   int checked;

   function new();
      att_c = '0; relf_c = '0; rels_c = '0; watt_c = '0; wrel_c = '0;
      thresh = '0; ratio = '0; bypass_on = 1'b1;
      errors = 0; checked = 0;
      for (int i = 0; i < 8; i++) begin
         fast_env[i] = '0; slow_env[i] = '0; blend_w[i] = '0;
      end
   endfunction

   function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
         CSR_ATTACK:       att_c = val;
         CSR_RELEASE_FAST: relf_c = val;
         CSR_RELEASE_SLOW: rels_c = val;
         CSR_WEIGHT_ATT:   watt_c = val;
         CSR_WEIGHT_REL:   wrel_c = val;
         CSR_THRESHOLD:    thresh = val[15:0];
         CSR_RATIO:        ratio = val[15:0];
         CSR_BYPASS:       bypass_on = val[0];
         default: ;
      endcase
   endfunction

   function logic [63:0] one_pole(logic [63:0] c, logic [63:0] x, logic [63:0] t);
      return (c * x + ((64'd1 << 24) - c) * t + (64'd1 << 23)) >> 24;
   endfunction

   function logic [63:0] mix_env(logic [63:0] f, logic [63:0] s, logic [63:0] w);
      return (f * ((64'd1 << 24) - w) + s * w + (64'd1 << 23)) >> 24;
   endfunction

   // attenuation of an envelope below full scale, Q7.8
   function logic [63:0] env_atten_db(logic [63:0] env);
      int p;
      logic [63:0] m, frac, l;
      p = 31;
      frac = 0;
      if (env == 0) return 64'd30720;
      while (env[p] == 1'b0) p--;
      m = env << (31 - p);
      for (int k = 0; k < 16; k++) begin
         m = (m * m + (64'd1 << 30)) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            frac = frac | 64'd1;
            m = m >> 1;
         end
      end
      l = ((64'(32 - p)) << 16) - frac;
      return (l * 64'd197283 + (64'd1 << 23)) >> 24;
   endfunction

   function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // linear gain for a reduction in dB, Q1.24
   function logic [63:0] gain_for(logic [63:0] red);
      logic [63:0] e, ip, f, v, r, g;
      e = (red * 64'd2786635 + (64'd1 << 15)) >> 16;
      ip = e >> 16;
      f = e & 64'hFFFF;
      v = 64'd1 << 30;
      r = 64'd1 << 29;
      for (int k = 15; k >= 0; k--) begin
         r = int_sqrt(r << 30);
         if (f[k]) v = (v * r + (64'd1 << 29)) >> 30;
      end
      g = (v + 64'd32) >> 6;
      if (ip >= 31) return 0;
      return g >> ip;
   endfunction

   // note an accepted sample: update state, queue the expected word
   function void note_sample(req_word_type w);
      rsp_word_type exp_w;
      int ch;
      logic signed [63:0] s, over;
      logic [63:0] mag, rect, prev, env, red, g, ym;
      logic attacking;
      ch = w.channel;
      s = w.sample_in;
      exp_w.channel_out = w.channel;
      exp_w.sample_out = w.sample_in;
      exp_w.reduction_db = '0;
      mag = (s < 0) ? -s : s;
      rect = (mag * mag) >> 14;
      if (rect > 64'hFFFF_FFFF) rect = 64'hFFFF_FFFF;
      prev = mix_env(fast_env[ch], slow_env[ch], blend_w[ch]);
      attacking = rect > prev;
      if (attacking) begin
         blend_w[ch] = 24'(one_pole(watt_c, blend_w[ch], 0));
         fast_env[ch] = 32'(one_pole(att_c, fast_env[ch], rect));
         slow_env[ch] = 32'(one_pole(att_c, slow_env[ch], rect));
      end else begin
         blend_w[ch] = 24'(one_pole(wrel_c, blend_w[ch], 64'hFF_FFFF));
         fast_env[ch] = 32'(one_pole(relf_c, fast_env[ch], rect));
         slow_env[ch] = 32'(one_pole(rels_c, slow_env[ch], rect));
      end
      if (!bypass_on) begin
         env = mix_env(fast_env[ch], slow_env[ch], blend_w[ch]);
         over = -$signed(env_atten_db(env)) - 64'(thresh);
         if (over < 0) over = 0;
         red = (over * ratio + (64'd1 << 15)) >> 16;
         if (red > 30720) red = 30720;
         g = gain_for(red);
         ym = (mag * g + (64'd1 << 23)) >> 24;
         exp_w.sample_out = 24'((s < 0) ? -ym : ym);
         exp_w.reduction_db = red[14:0];
      end
      pending_words.push_back(exp_w);
   endfunction

   function void check_word(rsp_word_type got);
      rsp_word_type exp_w;
      if (pending_words.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      exp_w = pending_words.pop_front();
      checked++;
      if (got.channel_out !== exp_w.channel_out) begin
         $display("%0t: channel_out expected %0d actual %0d", $time,
                  exp_w.channel_out, got.channel_out);
         errors++;
      end
      if (got.sample_out !== exp_w.sample_out) begin
         $display("%0t: sample_out expected %0d actual %0d", $time,
                  exp_w.sample_out, got.sample_out);
         errors++;
      end
      if (got.reduction_db !== exp_w.reduction_db) begin
         $display("%0t: reduction_db expected %0d actual %0d", $time,
                  exp_w.reduction_db, got.reduction_db);
         errors++;
      end
   endfunction
endclass

module tb_dual_release_rms_compressor;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   compressor_scoreboard board;
   bit quiet_mode = 1'b0;   // no idling on either side
   int idle_cycles = 0;
   int sent_count = 0;

   dual_release_rms_compressor dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial board = new();

   // random stall on the result side; check every accepted word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_word(rsp_word);
         rsp_stall <= quiet_mode ? 1'b0 : ($urandom_range(99) < 37);
      end
   end

   // watchdog on cycles without any accepted word or register write
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d words outstanding", board.pending_words.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // valid stays up after the accept; drop it only for an idle gap or a drain
   task automatic send_sample(logic [2:0] ch, logic [23:0] smp);
      req_word_type w;
      w.channel = ch;
      w.sample_in = smp;
      // idle gap before the word
      while (!quiet_mode && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sample(w);
      sent_count++;
   endtask

   task automatic write_csr(logic [2:0] idx, logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // hold until every expected word has come back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic load_setting(logic [23:0] att, logic [23:0] rf, logic [23:0] rs,
                               logic [23:0] wa, logic [23:0] wr, logic [15:0] th,
                               logic [15:0] rat, logic byp);
      write_csr(CSR_ATTACK, att);
      write_csr(CSR_RELEASE_FAST, rf);
      write_csr(CSR_RELEASE_SLOW, rs);
      write_csr(CSR_WEIGHT_ATT, wa);
      write_csr(CSR_WEIGHT_REL, wr);
      write_csr(CSR_THRESHOLD, {8'h00, th});
      write_csr(CSR_RATIO, {8'h00, rat});
      write_csr(CSR_BYPASS, {23'd0, byp});
   endtask

   // random sample: mostly full-range or small values, some full-scale extremes
   function automatic logic [23:0] pick_sample();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return 24'h800000;
      if (sel == 1) return 24'h7FFFFF;
      if (sel < 5) return 24'($urandom_range(24'hFFFFFF));
      if (sel < 8) return 24'($signed($urandom_range(2047)) - 1024);
      return 24'($signed($urandom_range(131071)) - 65536);
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         quiet_mode = (i >= count / 2) && (i < count / 2 + count / 8);
         send_sample(3'($urandom_range(7)), pick_sample());
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bypass after reset, field extremes on channels 0, 3 and 7
      send_sample(3'd0, 24'h7FFFFF);
      send_sample(3'd7, 24'h800000);
      send_sample(3'd3, 24'h000000);
      send_sample(3'd0, 24'hFFFFFF);
      drain();

      // directed: compressing, full ratio, deepest threshold
      load_setting(24'h100000, 24'h010000, 24'h001000, 24'h200000, 24'h004000,
                   16'h8800, 16'hFFFF, 1'b0);
      send_sample(3'd1, 24'h7FFFFF);
      send_sample(3'd1, 24'h800000);
      send_sample(3'd1, 24'h000001);
      send_sample(3'd2, 24'h000000);
      send_sample(3'd5, 24'h400000);
      send_sample(3'd5, 24'hC00000);
      send_sample(3'd6, 24'h555555);
      send_sample(3'd4, 24'hAAAAAA);
      drain();

      // directed: coefficient extremes, threshold beyond range, zero ratio
      load_setting(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                   16'h7FFF, 16'h0000, 1'b0);
      send_sample(3'd1, 24'h7FFFFF);
      send_sample(3'd2, 24'h123456);
      drain();
      write_csr(CSR_RATIO, 24'h00FFFF);
      write_csr(CSR_THRESHOLD, 24'h008000);
      send_sample(3'd1, 24'h000010);
      send_sample(3'd7, 24'h7FFFFF);
      drain();

      // random phases over several settings
      load_setting(24'h080000, 24'h008000, 24'h000800, 24'h100000, 24'h002000,
                   16'hEC00, 16'hC000, 1'b0);
      random_phase(300);
      drain();
      load_setting(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
                   24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
                   24'($urandom_range(24'hFFFFFF)), 16'(-$urandom_range(30720)),
                   16'($urandom_range(16'hFFFF)), 1'b0);
      random_phase(300);
      drain();
      load_setting(24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
                   16'h0000, 16'h0000, 1'b1);
      random_phase(100);
      drain();
      load_setting(24'h200000, 24'h001000, 24'h000100, 24'h400000, 24'h000400,
                   16'hF600, 16'hFFFF, 1'b0);
      random_phase(300);
      drain();

      $display("Covered %0d samples and %0d checked words over six register settings,",
               sent_count, board.checked);
      $display("including bypass, extreme coefficients and saturated reduction.");
      if (board.errors == 0 && board.pending_words.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
